// ----- sv/mbrf_pkg.sv -----
// Modbus RTU request framer: shared constants, sequencer state type and the
// byte-wide CRC-16/MODBUS update function.
// No dependencies.
package mbrf_pkg;

	localparam int WORD_COUNT_DEFAULT = 5;
	localparam int WORD_COUNT_MAX     = 16;

	// control words held for the write frame; words past these are sent as zero
	localparam int WORDS_HELD = 5;
	localparam int WSEL_W     = $clog2(WORDS_HELD);

	localparam logic [7:0]  FC_READ_HOLD   = 8'h03;
	localparam logic [7:0]  FC_WRITE_MULTI = 8'h10;
	localparam logic [7:0]  WR_REG_HI      = 8'h01;
	localparam logic [7:0]  RD_REG_HI      = 8'h02;
	localparam logic [7:0]  RD_COUNT_LO    = 8'h08;
	localparam logic [7:0]  ZERO_BYTE      = 8'h00;
	localparam logic [7:0]  ADDR_RESET     = 8'h01;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] FORCE_MIN  = 16'd20;
	localparam logic [15:0] SPEED_MIN  = 16'd1;

	localparam int READ_BODY_LEN = 6;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEND = 2'b10
	} state_t;

	// fold one byte into the reflected CRC, bit by bit
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/modbus_rtu_request_framer_unit.sv -----
// A command beat sets ST_SEND; then the first byte is loaded into the output register.
// Throughput: one frame byte per cycle while the output is not stalled; a write frame
// of 7+2*WORD_COUNT+2 bytes (19 by default) or a read frame of 8 bytes holds in_stall
// high until its last byte is loaded, so no new command is taken mid-frame.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, stored device address back to 1.
// Modbus RTU request framer top level; uses mbrf_pkg.
// Builds write-multiple or read-holding request frames with a CRC-16/MODBUS trailer.
module modbus_rtu_request_framer_unit #(
	parameter int WORD_COUNT = mbrf_pkg::WORD_COUNT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  device_address,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [15:0] first_word,
	input  logic [15:0] close_force,
	input  logic [15:0] open_force,
	input  logic [15:0] fourth_word,
	input  logic [15:0] speed_word,
	input  logic        init_active,
	// frame byte channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);

	localparam int BODY_LEN = 7 + 2 * WORD_COUNT;
	localparam int IDX_W    = $clog2(BODY_LEN + 2);
	localparam logic [7:0] WC_BYTE = 8'(WORD_COUNT);
	localparam logic [7:0] BC_BYTE = 8'(2 * WORD_COUNT);

	mbrf_pkg::state_t state_q;
	logic [7:0]       addr_q;
	logic             cmd_q;
	logic [15:0]      words_q [mbrf_pkg::WORDS_HELD];
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       frame_byte_q;
	logic             last_byte_q;

	logic             in_beat;
	logic             load;
	logic [IDX_W-1:0] body_len;
	logic [IDX_W-1:0] wsel;
	logic [IDX_W-2:0] word_idx;
	logic [15:0]      word_val;
	logic [7:0]       next_byte;
	logic             in_body;
	logic             is_last;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != mbrf_pkg::ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign load      = (state_q == mbrf_pkg::ST_SEND) && (!out_valid_q || !out_stall);

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;

	assign body_len = (cmd_q == mbrf_pkg::CMD_READ) ? IDX_W'(mbrf_pkg::READ_BODY_LEN)
		: IDX_W'(BODY_LEN);
	assign in_body  = idx_q < body_len;
	assign is_last  = idx_q == body_len + IDX_W'(1);
	assign wsel     = idx_q - IDX_W'(7);
	assign word_idx = wsel[IDX_W-1:1];

	always_comb begin
		if (word_idx < (IDX_W-1)'(mbrf_pkg::WORDS_HELD)) begin
			word_val = words_q[word_idx[mbrf_pkg::WSEL_W-1:0]];
		end else begin
			word_val = 16'h0000;
		end
	end

	// pick the byte at the current frame position
	always_comb begin
		next_byte = mbrf_pkg::ZERO_BYTE;
		priority if (!in_body) begin
			next_byte = is_last ? crc_q[15:8] : crc_q[7:0];
		end else if (idx_q == IDX_W'(0)) begin
			next_byte = addr_q;
		end else if (cmd_q == mbrf_pkg::CMD_READ) begin
			unique case (idx_q)
				IDX_W'(1): next_byte = mbrf_pkg::FC_READ_HOLD;
				IDX_W'(2): next_byte = mbrf_pkg::RD_REG_HI;
				IDX_W'(5): next_byte = mbrf_pkg::RD_COUNT_LO;
				default:   next_byte = mbrf_pkg::ZERO_BYTE;
			endcase
		end else if (idx_q == IDX_W'(1)) begin
			next_byte = mbrf_pkg::FC_WRITE_MULTI;
		end else if (idx_q == IDX_W'(2)) begin
			next_byte = mbrf_pkg::WR_REG_HI;
		end else if (idx_q == IDX_W'(5)) begin
			next_byte = WC_BYTE;
		end else if (idx_q == IDX_W'(6)) begin
			next_byte = BC_BYTE;
		end else if (idx_q >= IDX_W'(7)) begin
			next_byte = wsel[0] ? word_val[7:0] : word_val[15:8];
		end else begin
			next_byte = mbrf_pkg::ZERO_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= mbrf_pkg::ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			addr_q <= device_address;
		end
	end

	// command capture with word adjustments applied up front
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q      <= command;
			words_q[0] <= init_active ? 16'h0000 : first_word;
			words_q[1] <= (close_force < mbrf_pkg::FORCE_MIN) ? mbrf_pkg::FORCE_MIN
				: close_force;
			words_q[2] <= (open_force < mbrf_pkg::FORCE_MIN) ? mbrf_pkg::FORCE_MIN
				: open_force;
			words_q[3] <= fourth_word;
			words_q[4] <= (speed_word == 16'h0000) ? mbrf_pkg::SPEED_MIN : speed_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbrf_pkg::ST_IDLE;
			idx_q   <= '0;
			crc_q   <= mbrf_pkg::CRC_INIT;
		end else begin
			unique case (state_q)
				mbrf_pkg::ST_IDLE: begin
					if (in_beat) begin
						state_q <= mbrf_pkg::ST_SEND;
						idx_q   <= '0;
						crc_q   <= mbrf_pkg::CRC_INIT;
					end
				end
				mbrf_pkg::ST_SEND: begin
					if (load) begin
						idx_q <= idx_q + IDX_W'(1);
						if (in_body) begin
							crc_q <= mbrf_pkg::crc_byte(crc_q, next_byte);
						end
						if (is_last) begin
							state_q <= mbrf_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= mbrf_pkg::ST_IDLE;
			endcase
		end
	end

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_byte_q <= next_byte;
			last_byte_q  <= is_last;
		end
	end

endmodule

// ----- sv/mbrf_checker.sv -----
// Port-level checks for the Modbus RTU request framer, bound to the top level.
// Uses no package content beyond the top level's ports.
module mbrf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic       last_byte
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(last_byte))
		else $error("frame byte changed while stalled");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("command beat did not start a frame");

	a_done_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid && last_byte)
		else $error("frame ended without a pending last byte");

endmodule

bind modbus_rtu_request_framer_unit mbrf_checker u_mbrf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_byte (frame_byte),
	.last_byte  (last_byte)
);
